// ===== hw/rtl/char_lcd_buffer_refresh_defines.svh =====
// Assertion macros shared by the character display front end RTL.
`ifndef CHAR_LCD_BUFFER_REFRESH_DEFINES_SVH
`define CHAR_LCD_BUFFER_REFRESH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCDBR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdbr assertion failed");

// Next-cycle implication, checked outside reset.
`define LCDBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdbr assertion failed");

`endif

// ===== hw/rtl/lcdbr_pkg.sv =====
// Types, constants and codes of the character display front end.
package lcdbr_pkg;

  localparam int NUM_LINES  = 2;
  localparam int LINE_CHARS = 16;

  localparam int TEXT_DEPTH = NUM_LINES * LINE_CHARS;
  localparam int ADDR_W     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int LINE_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int COL_W      = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int CNT_W      = (COL_W > 3) ? COL_W : 3;

  localparam int SETUP_COUNT = 5;

  localparam logic [7:0] SPACE_CODE      = 8'h20;
  localparam logic [7:0] SET_ADDR_CMD    = 8'h80;
  localparam logic [7:0] DDRAM_LINE_STEP = 8'h40;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_CLEAR   = 3'd1;
  localparam logic [2:0] ACT_GOTO    = 3'd2;
  localparam logic [2:0] ACT_PUT     = 3'd3;
  localparam logic [2:0] ACT_REFRESH = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] target_line;
    logic [7:0] target_column;
    logic [7:0] character;
  } lcdbr_in_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } lcdbr_out_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } text_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } text_rd_t;

  function automatic logic [7:0] setup_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h28;
      3'd1:    cmd = 8'h28;
      3'd2:    cmd = 8'h0C;
      3'd3:    cmd = 8'h01;
      3'd4:    cmd = 8'h06;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

// ===== hw/rtl/lcdbr_text_mem.sv =====
// Text buffer memory with per-entry valid bits; an unwritten entry reads as a space.
module lcdbr_text_mem
  import lcdbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  text_wr_t   wr,
  input  text_rd_t   rd,
  output logic [7:0] rd_data
);

  logic [7:0]            mem [TEXT_DEPTH];
  logic [TEXT_DEPTH-1:0] valid_r;
  logic [7:0]            rd_data_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : SPACE_CODE;

endmodule

// ===== hw/rtl/lcdbr_ctrl.sv =====
// Sequencer: cursor, dirty flags, setup command run and line refresh stream.
`include "char_lcd_buffer_refresh_defines.svh"
module lcdbr_ctrl
  import lcdbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lcdbr_in_t  in_item,
  output logic       out_valid,
  output lcdbr_out_t out_item,
  output logic       mem_clear,
  output text_wr_t   mem_wr,
  output text_rd_t   mem_rd,
  input  logic [7:0] mem_rd_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_ADDR  = 2'd2;
  localparam logic [1:0] S_DATA  = 2'd3;

  localparam logic [CNT_W-1:0] SETUP_LAST = CNT_W'(SETUP_COUNT - 1);
  localparam logic [CNT_W-1:0] COL_LAST   = CNT_W'(LINE_CHARS - 1);

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [LINE_W-1:0]    line_r, line_nxt;
  logic [NUM_LINES-1:0] dirty_r, dirty_nxt;
  logic [7:0]           cur_line_r, cur_line_nxt;
  logic [7:0]           cur_col_r, cur_col_nxt;

  logic              accept;
  logic              first_found;
  logic [LINE_W-1:0] first_line;
  logic              next_found;
  logic [LINE_W-1:0] next_line;
  logic [7:0]        wline;
  logic [7:0]        wcol;

  function automatic addr_t text_addr(input logic [LINE_W-1:0] ln,
                                      input logic [COL_W-1:0] col);
    return ADDR_W'(int'(ln) * LINE_CHARS + int'(col));
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    first_found = 1'b0;
    first_line  = '0;
    next_found  = 1'b0;
    next_line   = '0;
    for (int j = NUM_LINES - 1; j >= 0; j--) begin
      if (dirty_r[j]) begin
        first_found = 1'b1;
        first_line  = LINE_W'(j);
      end
      if (dirty_r[j] && (j > int'(line_r))) begin
        next_found = 1'b1;
        next_line  = LINE_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    line_nxt     = line_r;
    dirty_nxt    = dirty_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    mem_clear    = 1'b0;
    mem_wr       = '0;
    mem_rd       = '0;
    out_valid    = 1'b0;
    out_item     = '0;
    wline        = cur_line_r;
    wcol         = cur_col_r;

    if (accept) begin
      case (in_item.action)
        ACT_INIT, ACT_CLEAR: begin
          mem_clear    = 1'b1;
          dirty_nxt    = '1;
          cur_line_nxt = '0;
          cur_col_nxt  = '0;
          if (in_item.action == ACT_INIT) begin
            state_nxt = S_SETUP;
            cnt_nxt   = '0;
          end
        end
        ACT_GOTO: begin
          cur_line_nxt = in_item.target_line;
          cur_col_nxt  = in_item.target_column;
        end
        ACT_PUT: begin
          if ((in_item.character != 8'h00) && (cur_line_r < 8'(NUM_LINES))) begin
            if (cur_col_r >= 8'(LINE_CHARS)) begin
              wline = cur_line_r + 8'd1;
              wcol  = '0;
            end
            cur_line_nxt = wline;
            cur_col_nxt  = wcol;
            if (wline < 8'(NUM_LINES)) begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = text_addr(wline[LINE_W-1:0], wcol[COL_W-1:0]);
              mem_wr.data = in_item.character;
              cur_col_nxt = wcol + 8'd1;
              dirty_nxt[wline[LINE_W-1:0]] = 1'b1;
            end
          end
        end
        ACT_REFRESH: begin
          if (first_found) begin
            state_nxt = S_ADDR;
            line_nxt  = first_line;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_SETUP: begin
        out_valid         = 1'b1;
        out_item.lcd_byte = setup_cmd(cnt_r[2:0]);
        if (cnt_r == SETUP_LAST) begin
          out_item.last = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ADDR: begin
        out_valid         = 1'b1;
        out_item.lcd_byte = SET_ADDR_CMD | 8'(int'(line_r) * int'(DDRAM_LINE_STEP));
        mem_rd.en         = 1'b1;
        mem_rd.addr       = text_addr(line_r, '0);
        cnt_nxt           = '0;
        state_nxt         = S_DATA;
      end
      S_DATA: begin
        out_valid         = 1'b1;
        out_item.lcd_byte = mem_rd_data;
        out_item.is_data  = 1'b1;
        if (cnt_r == COL_LAST) begin
          dirty_nxt[line_r] = 1'b0;
          if (next_found) begin
            line_nxt  = next_line;
            state_nxt = S_ADDR;
          end else begin
            out_item.last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cnt_nxt     = cnt_r + 1'b1;
          mem_rd.en   = 1'b1;
          mem_rd.addr = text_addr(line_r, COL_W'(cnt_r + 1'b1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      line_r     <= '0;
      dirty_r    <= '1;
      cur_line_r <= '0;
      cur_col_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      line_r     <= line_nxt;
      dirty_r    <= dirty_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
    end
  end

  `LCDBR_ASSERT_IMPL(a_setup_cnt, clk, rst_n, state_r == S_SETUP, cnt_r <= SETUP_LAST)
  `LCDBR_ASSERT_NEXT(a_addr_then_data, clk, rst_n, state_r == S_ADDR, state_r == S_DATA)
  `LCDBR_ASSERT_IMPL(a_sent_line_dirty, clk, rst_n, state_r == S_DATA, dirty_r[line_r])
  `LCDBR_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid && out_item.last, state_r == S_IDLE)

endmodule

// ===== hw/rtl/char_lcd_buffer_refresh.sv =====
// Top level of the character display front end: text buffer and refresh sequencer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  input    | start / busy       | in_item  (action, line, column, char)
//  result   | out_valid (strobe) | out_item (lcd_byte, is_data, last)
//
// Goto, put_char and clear finish at the accepting edge and never raise busy.
// Init holds busy while it sends the setup command run, one setup command beat per cycle.
// Refresh sends one beat per cycle: for each dirty line an address command plus sixteen
// characters, paced by the single text memory read port.
// Reset is synchronous; per-entry valid bits make the buffer read as spaces at once.
// The receiver cannot stall: each beat is on out_item for exactly one cycle.
module char_lcd_buffer_refresh
  import lcdbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lcdbr_in_t  in_item,
  output logic       out_valid,
  output lcdbr_out_t out_item
);

  logic       mem_clear;
  text_wr_t   mem_wr;
  text_rd_t   mem_rd;
  logic [7:0] mem_rd_data;

  lcdbr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mem_clear   (mem_clear),
    .mem_wr      (mem_wr),
    .mem_rd      (mem_rd),
    .mem_rd_data (mem_rd_data)
  );

  lcdbr_text_mem u_text_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (mem_clear),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== bench/char_lcd_buffer_refresh_tb.sv =====
// Self-checking testbench for the character display front end: text buffer, cursor and refresh.

class lcd_text_model;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR_DISP   = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  logic [7:0] text [lcdbr_pkg::NUM_LINES][lcdbr_pkg::LINE_CHARS];
  bit         dirty [lcdbr_pkg::NUM_LINES];
  logic [7:0] cur_line;
  logic [7:0] cur_col;
  lcdbr_pkg::lcdbr_out_t pending_bytes[$];
  int failures;

  function new();
    failures = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (text[l, c]) text[l][c] = lcdbr_pkg::SPACE_CODE;
    foreach (dirty[l]) dirty[l] = 1'b1;
    cur_line = 8'd0;
    cur_col  = 8'd0;
  endfunction

  function void place_char(logic [7:0] ch);
    if (ch == 8'd0) return;
    if (cur_line >= lcdbr_pkg::NUM_LINES) return;
    if (cur_col >= lcdbr_pkg::LINE_CHARS) begin
      cur_col  = 8'd0;
      cur_line = cur_line + 8'd1;
      if (cur_line >= lcdbr_pkg::NUM_LINES) return;
    end
    text[cur_line][cur_col] = ch;
    cur_col = cur_col + 8'd1;
    dirty[cur_line] = 1'b1;
  endfunction

  function void accept_command(lcdbr_pkg::lcdbr_in_t cmd);
    lcdbr_pkg::lcdbr_out_t run[$];
    lcdbr_pkg::lcdbr_out_t b;
    logic [7:0] setup [5];
    setup = '{CMD_FUNCTION_SET, CMD_FUNCTION_SET, CMD_DISPLAY_ON, CMD_CLEAR_DISP,
              CMD_ENTRY_MODE};
    b.last = 1'b0;
    case (cmd.action)
      lcdbr_pkg::ACT_INIT: begin
        wipe();
        b.is_data = 1'b0;
        foreach (setup[i]) begin
          b.lcd_byte = setup[i];
          run.push_back(b);
        end
      end
      lcdbr_pkg::ACT_CLEAR: wipe();
      lcdbr_pkg::ACT_GOTO: begin
        cur_line = cmd.target_line;
        cur_col  = cmd.target_column;
      end
      lcdbr_pkg::ACT_PUT: place_char(cmd.character);
      lcdbr_pkg::ACT_REFRESH: begin
        for (int l = 0; l < lcdbr_pkg::NUM_LINES; l++) begin
          if (!dirty[l]) continue;
          b.is_data  = 1'b0;
          b.lcd_byte = lcdbr_pkg::SET_ADDR_CMD | 8'(l * lcdbr_pkg::DDRAM_LINE_STEP);
          run.push_back(b);
          b.is_data = 1'b1;
          for (int c = 0; c < lcdbr_pkg::LINE_CHARS; c++) begin
            b.lcd_byte = text[l][c];
            run.push_back(b);
          end
          dirty[l] = 1'b0;
        end
      end
      default: ;
    endcase
    if (run.size() > 0) begin
      b = run.pop_back();
      b.last = 1'b1;
      run.push_back(b);
    end
    foreach (run[i]) pending_bytes.push_back(run[i]);
  endfunction

  function void check_byte(lcdbr_pkg::lcdbr_out_t got);
    lcdbr_pkg::lcdbr_out_t want;
    if (pending_bytes.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected beat byte=%h is_data=%b last=%b",
                 $realtime, got.lcd_byte, got.is_data, got.last);
      return;
    end
    want = pending_bytes.pop_front();
    if (got.lcd_byte !== want.lcd_byte || got.is_data !== want.is_data ||
        got.last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display({"%0t: beat mismatch expected byte=%h is_data=%b last=%b, ",
                  "got byte=%h is_data=%b last=%b"},
                 $realtime, want.lcd_byte, want.is_data, want.last,
                 got.lcd_byte, got.is_data, got.last);
    end
  endfunction
endclass

module char_lcd_buffer_refresh_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdbr_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  lcdbr_in_t  in_item = '0;
  logic       out_valid;
  lcdbr_out_t out_item;

  lcd_text_model shadow = new();

  char_lcd_buffer_refresh DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.check_byte(out_item);
      if (start && !busy) shadow.accept_command(in_item);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic lcdbr_in_t make_cmd(logic [2:0] act, logic [7:0] ln, logic [7:0] col,
                                         logic [7:0] ch);
    lcdbr_in_t cmd;
    cmd.action        = act;
    cmd.target_line   = ln;
    cmd.target_column = col;
    cmd.character     = ch;
    return cmd;
  endfunction

  task automatic issue(input lcdbr_in_t cmd, input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int counted;
    int idle_pct;
    int pick;
    lcdbr_in_t cmd;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(make_cmd(ACT_REFRESH, rnd8(), rnd8(), rnd8()), 22);
    issue(make_cmd(ACT_REFRESH, rnd8(), rnd8(), rnd8()), 22);
    issue(make_cmd(ACT_INIT, rnd8(), rnd8(), rnd8()), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h41), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'hFF), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h00), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h01), 22);
    issue(make_cmd(ACT_GOTO, 8'd0, 8'd15, rnd8()), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h7E), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h80), 22);
    issue(make_cmd(ACT_GOTO, 8'd1, 8'd200, rnd8()), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h55), 22);
    issue(make_cmd(ACT_GOTO, 8'd255, 8'd255, rnd8()), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'h33), 22);
    issue(make_cmd(ACT_GOTO, 8'd0, 8'd255, rnd8()), 22);
    issue(make_cmd(ACT_PUT, rnd8(), rnd8(), 8'hAA), 22);
    issue(make_cmd(ACT_REFRESH, rnd8(), rnd8(), rnd8()), 22);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      issue(make_cmd(3'(a), rnd8(), rnd8(), rnd8()), 22);
    issue(make_cmd(ACT_CLEAR, rnd8(), rnd8(), rnd8()), 22);
    issue(make_cmd(ACT_REFRESH, rnd8(), rnd8(), rnd8()), 22);

    counted = 0;
    while (counted < 100) begin
      idle_pct = (counted < 34) ? 22 : (counted < 67) ? 52 : 0;
      cmd = make_cmd(ACT_PUT, rnd8(), rnd8(), rnd8());
      pick = $urandom_range(99);
      if (pick < 45) begin
        cmd.character = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end else if (pick < 60) begin
        cmd.action = ACT_GOTO;
        if ($urandom_range(4) != 0) begin
          cmd.target_line   = 8'($urandom_range(NUM_LINES - 1));
          cmd.target_column = 8'($urandom_range(LINE_CHARS + 1));
        end
      end else if (pick < 80) begin
        cmd.action = ACT_REFRESH;
      end else if (pick < 86) begin
        cmd.action = ACT_CLEAR;
      end else if (pick < 92) begin
        cmd.action = ACT_INIT;
      end else begin
        cmd.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      issue(cmd, idle_pct);
      if (cmd.action <= ACT_REFRESH) counted++;
    end
    start <= 1'b0;

    while (shadow.pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
